// File: rtl/core/tfp_pkg.sv
// Shared types and constants for the thruster force-to-pulse block.
// Item structs, curve codes, fixed-point widths and reciprocal constants.
// No dependencies.
package tfp_pkg;

  // Field widths
  localparam int IDX_W   = 3;
  localparam int FORCE_W = 16;
  localparam int PULSE_W = 11;

  // Thruster set and direction mask
  localparam int THRUSTER_COUNT = 6;
  localparam int MASK_BITS      = 6;
  localparam int DIR_LIMIT      = (THRUSTER_COUNT < MASK_BITS) ? THRUSTER_COUNT : MASK_BITS;
  localparam int MASK_EXT       = 1 << IDX_W;

  // Q format of the force
  localparam int FORCE_FRAC_BITS = 8;

  // Power widths: |f|, f^2, f^3
  localparam int SQ_W = 2 * FORCE_W;
  localparam int CU_W = 3 * FORCE_W;

  // Signed numerator width, covers the cubic curve over the whole Q range
  localparam int NUM_W = ((3 * FORCE_FRAC_BITS > 22) ? 3 * FORCE_FRAC_BITS : 22) + 27;

  // Quotient before the final divide by 10 or 100, and reciprocal multiply
  localparam int X_W         = 18;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_DIV10  = RECIP_W'(1677722);
  localparam logic [RECIP_W-1:0] RECIP_DIV100 = RECIP_W'(167773);

  // Pulse limits in microseconds
  localparam logic [PULSE_W-1:0] PULSE_MIN = PULSE_W'(1000);
  localparam logic [PULSE_W-1:0] PULSE_MID = PULSE_W'(1500);
  localparam logic [PULSE_W-1:0] PULSE_MAX = PULSE_W'(2000);

  // Which curve an item uses
  typedef enum logic [1:0] {
    CURVE_CW_POS  = 2'd0,
    CURVE_CCW_POS = 2'd1,
    CURVE_CW_NEG  = 2'd2,
    CURVE_CCW_NEG = 2'd3
  } curve_t;

  // Input item
  typedef struct packed {
    logic [IDX_W-1:0]          thruster_index;
    logic signed [FORCE_W-1:0] force_q8_8;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [IDX_W-1:0]   thruster_id;
    logic [PULSE_W-1:0] pulse_us;
  } pulse_t;

  // Power stages to numerator stages
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] id;
    curve_t           curve;
    logic             zero;
    logic [FORCE_W-1:0] f;
    logic [SQ_W-1:0]    f2;
    logic [CU_W-1:0]    f3;
  } pow_t;

  // Clamp stage to final scale stage
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   id;
    logic               sat;
    logic [PULSE_W-1:0] sat_val;
    logic [X_W-1:0]     x;
    logic               div100;
  } scl_t;

endpackage

// File: rtl/core/tfp_power.sv
// Front of the pipeline: decode, magnitude, square and cube of the force.
// Three register stages. Depends on tfp_pkg.
module tfp_power
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  input  logic [MASK_BITS-1:0] dir_mask,
  output pow_t                 pw
);

  // Stage A: decoded item
  logic               a_valid;
  logic [IDX_W-1:0]   a_id;
  curve_t             a_curve;
  logic               a_zero;
  logic [FORCE_W-1:0] a_f;

  // Stage B: square
  logic               b_valid;
  logic [IDX_W-1:0]   b_id;
  curve_t             b_curve;
  logic               b_zero;
  logic [FORCE_W-1:0] b_f;
  logic [SQ_W-1:0]    b_f2;

  // Stage C: cube
  logic               c_valid;
  logic [IDX_W-1:0]   c_id;
  curve_t             c_curve;
  logic               c_zero;
  logic [FORCE_W-1:0] c_f;
  logic [SQ_W-1:0]    c_f2;
  logic [CU_W-1:0]    c_f3;

  logic                neg;
  logic                ccw;
  logic [MASK_EXT-1:0] mask_ext;
  logic [FORCE_W-1:0]  mag;
  curve_t              curve_next;

  // Direction lookup; indexes past the mask read as clockwise
  assign mask_ext = {{(MASK_EXT - MASK_BITS){1'b0}}, dir_mask};
  assign ccw = ({1'b0, cmd.thruster_index} < (IDX_W + 1)'(DIR_LIMIT)) &&
               mask_ext[cmd.thruster_index];
  assign neg = cmd.force_q8_8[FORCE_W-1];
  // Most negative force wraps to its true magnitude as unsigned
  assign mag = neg ? (~cmd.force_q8_8 + FORCE_W'(1)) : cmd.force_q8_8;

  always_comb begin
    case ({neg, ccw})
      2'b00:   curve_next = CURVE_CW_POS;
      2'b01:   curve_next = CURVE_CCW_POS;
      2'b10:   curve_next = CURVE_CW_NEG;
      default: curve_next = CURVE_CCW_NEG;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= cmd_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_id    <= cmd.thruster_index;
      a_curve <= curve_next;
      a_zero  <= (cmd.force_q8_8 == '0);
      a_f     <= mag;

      b_id    <= a_id;
      b_curve <= a_curve;
      b_zero  <= a_zero;
      b_f     <= a_f;
      b_f2    <= SQ_W'(a_f) * SQ_W'(a_f);

      c_id    <= b_id;
      c_curve <= b_curve;
      c_zero  <= b_zero;
      c_f     <= b_f;
      c_f2    <= b_f2;
      c_f3    <= CU_W'(b_f2) * CU_W'(b_f);
    end
  end

  assign pw = '{valid: c_valid, id: c_id, curve: c_curve, zero: c_zero,
                f: c_f, f2: c_f2, f3: c_f3};

endmodule

// File: rtl/core/tfp_poly.sv
// Middle of the pipeline: curve numerator, then scale and clamp.
// Two register stages. Depends on tfp_pkg.
module tfp_poly
  import tfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  pow_t pw,
  output scl_t sc
);

  localparam int SH1 = FORCE_FRAC_BITS;
  localparam int SH2 = 2 * FORCE_FRAC_BITS;
  localparam int SH3 = 3 * FORCE_FRAC_BITS;

  // Curve coefficients, scaled so every curve is exact in integers
  localparam logic signed [NUM_W-1:0] K3     = NUM_W'(3);
  localparam logic signed [NUM_W-1:0] K7     = NUM_W'(7);
  localparam logic signed [NUM_W-1:0] K160   = NUM_W'(160);
  localparam logic signed [NUM_W-1:0] K310   = NUM_W'(310);
  localparam logic signed [NUM_W-1:0] K321   = NUM_W'(321);
  localparam logic signed [NUM_W-1:0] K377   = NUM_W'(377);
  localparam logic signed [NUM_W-1:0] K3570  = NUM_W'(3570);
  localparam logic signed [NUM_W-1:0] C_CWP  = NUM_W'(14875) <<< SH2;
  localparam logic signed [NUM_W-1:0] C_CCWP = NUM_W'(149640) <<< SH3;
  localparam logic signed [NUM_W-1:0] C_CWN  = NUM_W'(15270) <<< SH2;
  localparam logic signed [NUM_W-1:0] C_CCWN = NUM_W'(15219) <<< SH2;

  // Clamp limits on the shifted numerator (pulse limit times divisor)
  localparam logic signed [NUM_W-1:0] L_1E4   = NUM_W'(10000);
  localparam logic signed [NUM_W-1:0] L_15E3  = NUM_W'(15000);
  localparam logic signed [NUM_W-1:0] L_2E4   = NUM_W'(20000);
  localparam logic signed [NUM_W-1:0] L_1E5   = NUM_W'(100000);
  localparam logic signed [NUM_W-1:0] L_15E4  = NUM_W'(150000);

  // Stage D: numerator
  logic                    d_valid;
  logic [IDX_W-1:0]        d_id;
  curve_t                  d_curve;
  logic                    d_zero;
  logic signed [NUM_W-1:0] d_num;

  // Stage E: clamp result
  logic               e_valid;
  logic [IDX_W-1:0]   e_id;
  logic               e_sat;
  logic [PULSE_W-1:0] e_sat_val;
  logic [X_W-1:0]     e_x;
  logic               e_div100;

  logic signed [NUM_W-1:0] fe, f2e, f3e, fs1, fs2, f2s1;
  logic signed [NUM_W-1:0] num_next;
  logic signed [NUM_W-1:0] t, lo_c, hi_c;
  logic [PULSE_W-1:0]      lo_p, hi_p;
  logic                    sat_next;
  logic [PULSE_W-1:0]      sat_val_next;

  assign fe   = signed'(NUM_W'(pw.f));
  assign f2e  = signed'(NUM_W'(pw.f2));
  assign f3e  = signed'(NUM_W'(pw.f3));
  assign fs1  = fe <<< SH1;
  assign fs2  = fe <<< SH2;
  assign f2s1 = f2e <<< SH1;

  // Numerator of the selected curve
  always_comb begin
    case (pw.curve)
      CURVE_CW_POS:  num_next = (f2e <<< 2) - K321 * fs1 + C_CWP;
      CURVE_CCW_POS: num_next = K160 * f2s1 - K3 * f3e - K3570 * fs2 + C_CCWP;
      CURVE_CW_NEG:  num_next = K377 * fs1 - K7 * f2e + C_CWN;
      default:       num_next = K310 * fs1 - (f2e <<< 2) + C_CCWN;
    endcase
  end

  // Drop the Q fraction (floor) and pick the clamp window
  always_comb begin
    case (d_curve)
      CURVE_CW_POS: begin
        t = d_num >>> SH2; lo_c = L_1E4;  hi_c = L_15E3;
        lo_p = PULSE_MIN;  hi_p = PULSE_MID;
      end
      CURVE_CCW_POS: begin
        t = d_num >>> SH3; lo_c = L_1E5;  hi_c = L_15E4;
        lo_p = PULSE_MIN;  hi_p = PULSE_MID;
      end
      default: begin
        t = d_num >>> SH2; lo_c = L_15E3; hi_c = L_2E4;
        lo_p = PULSE_MID;  hi_p = PULSE_MAX;
      end
    endcase
  end

  always_comb begin
    sat_next     = 1'b1;
    sat_val_next = PULSE_MID;
    if (d_zero) begin
      sat_val_next = PULSE_MID;
    end else if (t < lo_c) begin
      sat_val_next = lo_p;
    end else if (t >= hi_c) begin
      sat_val_next = hi_p;
    end else begin
      sat_next = 1'b0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      d_valid <= pw.valid;
      e_valid <= d_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      d_id      <= pw.id;
      d_curve   <= pw.curve;
      d_zero    <= pw.zero;
      d_num     <= num_next;

      e_id      <= d_id;
      e_sat     <= sat_next;
      e_sat_val <= sat_val_next;
      e_x       <= t[X_W-1:0];
      e_div100  <= (d_curve == CURVE_CCW_POS);
    end
  end

  assign sc = '{valid: e_valid, id: e_id, sat: e_sat, sat_val: e_sat_val,
                x: e_x, div100: e_div100};

endmodule

// File: rtl/core/tfp_scale.sv
// Last pipeline stage: divide by 10 or 100 through a reciprocal multiply,
// and the output register. Depends on tfp_pkg.
module tfp_scale
  import tfp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  scl_t   sc,
  output logic   pulse_valid,
  output pulse_t pulse
);

  logic [RECIP_W-1:0]     recip;
  logic [X_W+RECIP_W-1:0] prod;
  logic [PULSE_W-1:0]     quot;

  // Truncating divide; exact over the unclamped quotient range
  assign recip = sc.div100 ? RECIP_DIV100 : RECIP_DIV10;
  assign prod  = (X_W + RECIP_W)'(sc.x) * (X_W + RECIP_W)'(recip);
  assign quot  = prod[RECIP_SHIFT +: PULSE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (en) begin
      pulse_valid <= sc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pulse.thruster_id <= sc.id;
      pulse.pulse_us    <= sc.sat ? sc.sat_val : quot;
    end
  end

endmodule

// File: rtl/core/thruster_force_to_pulse.sv
// Top level of the thruster force-to-pulse converter: direction register,
// pipeline enable and the three pipeline sections. Depends on tfp_pkg,
// tfp_power, tfp_poly and tfp_scale.
//
// Usage:
//   cmd channel: an item (thruster index, signed Q8.8 force) is taken at a
//   rising edge with cmd_valid high and cmd_stall low.
//   pulse channel: an item (thruster id, pulse width in us) is taken at a
//   rising edge with pulse_valid high and pulse_stall low.
//   cfg_we/cfg_wdata write the 6-bit direction mask (1 = counter-clockwise);
//   write it only while no item is in flight.
// Pipeline: six register stages (decode, square, cube, numerator, clamp,
//   divide/output).
// Throughput: one item per cycle unless stalled; the pipeline moves as one unit.
// Stall: while pulse_stall holds a waiting result, the whole pipeline
//   freezes and cmd_stall is raised; nothing is dropped or repeated.
// Reset: synchronous rst clears every valid bit and the mask to clockwise.
module thruster_force_to_pulse
  import tfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 pulse_valid,
  input  logic                 pulse_stall,
  output pulse_t               pulse,
  input  logic                 cfg_we,
  input  logic [MASK_BITS-1:0] cfg_wdata
);

  logic [MASK_BITS-1:0] dir_mask;
  logic                 en;
  pow_t                 pw;
  scl_t                 sc;

  // Direction mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_mask <= '0;
    end else if (cfg_we) begin
      dir_mask <= cfg_wdata;
    end
  end

  // Pipeline advances unless the output item is held
  assign en        = !(pulse_valid && pulse_stall);
  assign cmd_stall = !en;

  tfp_power u_power (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .dir_mask  (dir_mask),
    .pw        (pw)
  );

  tfp_poly u_poly (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .pw  (pw),
    .sc  (sc)
  );

  tfp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .sc          (sc),
    .pulse_valid (pulse_valid),
    .pulse       (pulse)
  );

endmodule

// File: rtl/core/tfp_checker.sv
// Port-level checks for thruster_force_to_pulse, and the bind that
// attaches them. Depends on tfp_pkg and the top level.
module tfp_checker
  import tfp_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   cmd_stall,
  input logic   pulse_valid,
  input logic   pulse_stall,
  input pulse_t pulse
);

  // Pulse width always inside the servo range
  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    pulse_valid |-> (pulse.pulse_us >= PULSE_MIN) && (pulse.pulse_us <= PULSE_MAX))
    else $error("pulse width out of range");

  // A held result item stays put
  a_pulse_hold: assert property (@(posedge clk) disable iff (rst)
    pulse_valid && pulse_stall |=> pulse_valid && $stable(pulse))
    else $error("held pulse item changed");

  // Input is pushed back only by a held result item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> pulse_valid && pulse_stall)
    else $error("cmd stalled without a held result");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pulse_valid && !cmd_stall)
    else $error("pipeline not empty after reset");

endmodule

bind thruster_force_to_pulse tfp_checker u_tfp_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_stall   (cmd_stall),
  .pulse_valid (pulse_valid),
  .pulse_stall (pulse_stall),
  .pulse       (pulse)
);

// File: verif/testbench.sv
// Self-checking testbench for thruster_force_to_pulse: directed and random force
// items under several direction masks, random idling and stalls on both channels.
// Depends on tfp_pkg and the thruster_force_to_pulse RTL.
`timescale 1ns / 100ps

module testbench;
  import tfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int HOLD_AFTER  = 300;
  localparam int END_CYCLES  = 20;
  localparam int REPORT_MAX  = 10;

  // What one queued stimulus step does
  typedef enum logic [1:0] {
    STEP_CMD,
    STEP_MASK,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t           kind;
    cmd_t                 cmd;
    logic [MASK_BITS-1:0] mask;
  } step_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cmd_valid   = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd         = '0;
  logic                 pulse_valid;
  logic                 pulse_stall = 1'b0;
  pulse_t               pulse;
  logic                 cfg_we      = 1'b0;
  logic [MASK_BITS-1:0] cfg_wdata   = '0;

  step_t                pending[$];
  pulse_t               pulses_due[$];
  logic [MASK_BITS-1:0] mask_model   = '0;
  int                   cmds_taken   = 0;
  int                   pulses_taken = 0;
  int                   mismatches   = 0;
  int                   cycle        = 0;
  int                   hold_left    = 0;
  bit                   hold_done    = 1'b0;
  logic                 calm;

  // No idling on either side inside this window
  assign calm = (cycle >= 700) && (cycle < 1000);

  thruster_force_to_pulse dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .pulse_valid (pulse_valid),
    .pulse_stall (pulse_stall),
    .pulse       (pulse),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected pulse for one force item: exact integer curve, clamp, truncate
  function automatic pulse_t pulse_for_force(logic [IDX_W-1:0] idx,
                                             logic signed [FORCE_W-1:0] force_q,
                                             logic [MASK_BITS-1:0] mask);
    longint s1, s2, s3, f, f2, f3;
    longint num, den, lo, hi, p;
    logic   ccw;
    curve_t curve;
    pulse_t r;
    s1 = longint'(1) << FORCE_FRAC_BITS;
    s2 = s1 * s1;
    s3 = s2 * s1;
    f  = longint'(force_q);
    if (f < 0) f = -f;
    f2 = f * f;
    f3 = f2 * f;
    // indexes past the mask read as clockwise
    ccw = (int'(idx) < DIR_LIMIT) ? mask[idx] : 1'b0;
    if (force_q > 0) curve = ccw ? CURVE_CCW_POS : CURVE_CW_POS;
    else             curve = ccw ? CURVE_CCW_NEG : CURVE_CW_NEG;
    num = 0;
    den = 1;
    lo  = longint'(PULSE_MIN);
    hi  = longint'(PULSE_MID);
    case (curve)
      CURVE_CW_POS: begin
        num = 4 * f2 - 321 * f * s1 + 14875 * s2;
        den = 10 * s2;
      end
      CURVE_CCW_POS: begin
        num = -3 * f3 + 160 * f2 * s1 - 3570 * f * s2 + 149640 * s3;
        den = 100 * s3;
      end
      CURVE_CW_NEG: begin
        num = -7 * f2 + 377 * f * s1 + 15270 * s2;
        den = 10 * s2;
        lo  = longint'(PULSE_MID);
        hi  = longint'(PULSE_MAX);
      end
      default: begin
        num = -4 * f2 + 310 * f * s1 + 15219 * s2;
        den = 10 * s2;
        lo  = longint'(PULSE_MID);
        hi  = longint'(PULSE_MAX);
      end
    endcase
    if (force_q == 0)       p = longint'(PULSE_MID);
    else if (num <= lo * den) p = lo;
    else if (num >= hi * den) p = hi;
    else                      p = num / den;
    r.thruster_id = idx;
    r.pulse_us    = PULSE_W'(p);
    return r;
  endfunction

  task automatic add_cmd(int idx, int force_val);
    step_t s;
    s.kind                 = STEP_CMD;
    s.cmd.thruster_index   = IDX_W'(idx);
    s.cmd.force_q8_8       = FORCE_W'(force_val);
    s.mask                 = '0;
    pending.push_back(s);
  endtask

  task automatic add_mask(logic [MASK_BITS-1:0] m);
    step_t s;
    s.kind = STEP_MASK;
    s.cmd  = '0;
    s.mask = m;
    pending.push_back(s);
  endtask

  task automatic add_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    s.cmd  = '0;
    s.mask = '0;
    pending.push_back(s);
  endtask

  // Random items; most forces sit where the curves are not yet clamped
  task automatic add_random_items(int n);
    int idx;
    int v;
    int sel;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(9) == 0) ? int'($urandom_range(7))
                                     : int'($urandom_range(THRUSTER_COUNT - 1));
      sel = $urandom_range(99);
      if (sel < 10) begin
        v = int'($urandom_range(32)) - 16;
      end else if (sel < 55) begin
        v = int'($urandom_range(8191));
        if ($urandom_range(1) == 1) v = -v;
      end else if (sel < 65) begin
        case ($urandom_range(4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 1;
          3:       v = -1;
          default: v = 0;
        endcase
      end else begin
        v = int'($urandom_range(65535)) - 32768;
      end
      add_cmd(idx, v);
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle);
  endtask

  // Driver: offers queued items, writes the mask only with nothing in flight
  always @(posedge clk) begin : driver
    logic nxt_valid;
    logic nxt_we;
    nxt_valid = cmd_valid;
    nxt_we    = 1'b0;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        pulses_due.push_back(pulse_for_force(cmd.thruster_index, cmd.force_q8_8,
                                             mask_model));
        cmds_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending.size() != 0) begin
        case (pending[0].kind)
          STEP_CMD: begin
            if (calm || $urandom_range(99) >= 14) begin
              cmd       <= pending[0].cmd;
              nxt_valid = 1'b1;
              void'(pending.pop_front());
            end
          end
          STEP_MASK: begin
            if (cmds_taken == pulses_taken) begin
              cfg_wdata  <= pending[0].mask;
              mask_model = pending[0].mask;
              nxt_we     = 1'b1;
              void'(pending.pop_front());
            end
          end
          default: begin
            if (cmds_taken == pulses_taken) void'(pending.pop_front());
          end
        endcase
      end
    end
    cmd_valid <= nxt_valid;
    cfg_we    <= nxt_we;
  end

  // Monitor: checks each pulse item against the oldest expectation
  always @(posedge clk) begin : monitor
    pulse_t want;
    logic   nxt_stall;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (pulse_valid && !pulse_stall) begin
        pulses_taken <= pulses_taken + 1;
        if (pulses_due.size() == 0) begin
          report_mismatch("unexpected pulse item, pulse_us", -1, int'(pulse.pulse_us));
        end else begin
          want = pulses_due.pop_front();
          if (pulse.thruster_id !== want.thruster_id)
            report_mismatch("thruster_id", int'(want.thruster_id), int'(pulse.thruster_id));
          if (pulse.pulse_us !== want.pulse_us)
            report_mismatch("pulse_us", int'(want.pulse_us), int'(pulse.pulse_us));
        end
      end
      // one long hold-off so the pipeline fills and stalls its input
      if (hold_left != 0) begin
        nxt_stall = 1'b1;
        hold_left--;
      end else if (!hold_done && pulses_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = !calm && ($urandom_range(99) < 14);
      end
    end
    pulse_stall <= nxt_stall;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // directed, clockwise everywhere: zero, extremes, curve interiors, indexes 6 and 7
    add_mask(6'h00);
    add_cmd(0, 0);
    add_cmd(1, 1);
    add_cmd(2, 32767);
    add_cmd(3, -32768);
    add_cmd(4, -1);
    add_cmd(5, 256);
    add_cmd(0, -256);
    add_cmd(1, 5120);
    add_cmd(2, -7000);
    add_cmd(7, 1000);
    add_cmd(6, -3000);
    // directed, counter-clockwise everywhere; indexes 6 and 7 still clockwise
    add_mask(6'h3F);
    add_cmd(0, 0);
    add_cmd(1, 1);
    add_cmd(2, 32767);
    add_cmd(3, -32768);
    add_cmd(4, -1);
    add_cmd(5, 2560);
    add_cmd(0, -2560);
    add_cmd(6, 500);
    add_cmd(7, -500);
    add_cmd(5, 12800);
    add_cmd(3, -12800);
    // random phases, one mask each; a full drain in the middle of one
    add_mask(6'h15);
    add_random_items(167);
    add_mask(6'h3F);
    add_random_items(167);
    add_mask(MASK_BITS'($urandom));
    add_random_items(80);
    add_drain();
    add_random_items(87);
    add_mask(6'h00);
    add_random_items(167);
    add_mask(6'h2A);
    add_random_items(167);
    add_mask(MASK_BITS'($urandom));
    add_random_items(167);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || cmd_valid || cmds_taken != pulses_taken);
    repeat (END_CYCLES) @(posedge clk);

    if (mismatches == 0 && pulses_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tfp_pkg.sv
rtl/core/tfp_power.sv
rtl/core/tfp_poly.sv
rtl/core/tfp_scale.sv
rtl/core/thruster_force_to_pulse.sv
rtl/core/tfp_checker.sv
verif/testbench.sv
